// ===== hdl/sha1_hash_engine_assert.svh =====
// Assertion shorthands for the hash engine; clocked on clk, quiet during reset.
`ifndef SHA1_HASH_ENGINE_ASSERT_SVH
`define SHA1_HASH_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define SHA1_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SHA1_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sha1_pkg.sv =====
`timescale 1ns / 1ps

package sha1_pkg;

    localparam int ROUNDS = 80;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_DIGEST
    } state_t;

    // Padding progress of the current message.
    typedef enum logic [2:0]
    {
        PH_NONE,
        PH_MARK,
        PH_ZERO,
        PH_LEN,
        PH_DONE
    } phase_t;

    localparam logic [4:0][31:0] H_INIT =
    {
        32'hC3D2E1F0,
        32'h10325476,
        32'h98BADCFE,
        32'hEFCDAB89,
        32'h67452301
    };

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

    function automatic logic [31:0] sha1_f(input logic [6:0] t, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (t < 7'd20)
        begin
            f = (b & c) | (~b & d);
        end
        else if (t < 7'd40)
        begin
            f = b ^ c ^ d;
        end
        else if (t < 7'd60)
        begin
            f = (b & c) | (b & d) | (c & d);
        end
        else
        begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic logic [31:0] sha1_k(input logic [6:0] t);
        logic [31:0] k;
        if (t < 7'd20)
        begin
            k = K_0;
        end
        else if (t < 7'd40)
        begin
            k = K_1;
        end
        else if (t < 7'd60)
        begin
            k = K_2;
        end
        else
        begin
            k = K_3;
        end
        return k;
    endfunction

endpackage

// ===== hdl/sha1_hash_engine.sv =====
`timescale 1ns / 1ps
// SHA-1 engine. Message bytes come in on the msg channel, one per transaction:
// data_byte counts when byte_present is set, end_of_message closes the message
// (an end transaction with no byte is allowed, alone it hashes the empty message).
// The digest leaves on the digest channel as five transactions, word_number 0
// (most significant) to 4, last_word set on word 4.
// Throughput: bytes are taken while msg_stall is low; every completed 64-byte block
// then holds msg_stall high through 80 rounds in the single round adder and the
// chaining add. After the end transaction the padding (9 to 72 bytes) is written
// one byte per cycle, paused by one or two block compressions, and then the
// digest register is loaded.
// The digest sits in its own output register, so the next message is taken
// while digest words are still waiting; a stall on the digest channel only
// blocks the engine when a second digest is ready before the first has left.
// Reset (rst_n low, asynchronous) loads the initial chaining values, clears the
// bit and byte counts and drops digest_valid.
module sha1_hash_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        digest_valid,
    input  logic        digest_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_number,
    output logic        last_word
);
    import sha1_pkg::*;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [4:0][31:0]  chain_reg, chain_next;
    logic [4:0][31:0]  rv_reg, rv_next;
    logic [15:0][31:0] w_reg, w_next;
    logic [23:0]       acc_reg, acc_next;
    logic [5:0]        byte_cnt_reg, byte_cnt_next;
    logic [63:0]       bit_cnt_reg, bit_cnt_next;
    logic [6:0]        round_reg, round_next;
    logic [4:0][31:0]  dig_reg, dig_next;
    logic [2:0]        out_idx_reg, out_idx_next;
    logic              out_busy_reg, out_busy_next;

    logic        msg_take;
    logic        out_take;
    logic        wr_en;
    logic [7:0]  wr_byte;
    logic [7:0]  pad_byte;
    logic [2:0]  len_sel;
    logic        block_full;
    logic [31:0] round_sum;

    assign msg_take = msg_valid && !msg_stall;
    assign out_take = digest_valid && !digest_stall;

    // Length bytes go out most significant first at fill 56..63.
    assign len_sel = ~byte_cnt_reg[2:0];

    always_comb
    begin
        unique case (phase_reg)
            PH_MARK: pad_byte = PAD_MARK;
            PH_LEN:  pad_byte = bit_cnt_reg[{len_sel, 3'b000} +: 8];
            default: pad_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_byte = pad_byte;
        if (state_reg == ST_IDLE)
        begin
            wr_en   = msg_take && byte_present;
            wr_byte = data_byte;
        end
        else if (state_reg == ST_PAD)
        begin
            wr_en = 1'b1;
        end
    end

    assign block_full = wr_en && (byte_cnt_reg == 6'd63);

    assign round_sum = {rv_reg[0][26:0], rv_reg[0][31:27]}
                     + sha1_f(round_reg, rv_reg[1], rv_reg[2], rv_reg[3])
                     + rv_reg[4] + sha1_k(round_reg) + w_reg[0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_take && block_full)
                begin
                    state_next = ST_ROUND;
                end
                else if (msg_take && end_of_message)
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (block_full)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (round_reg == 7'(ROUNDS - 1))
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                priority if (phase_reg == PH_NONE)
                begin
                    state_next = ST_IDLE;
                end
                else if (phase_reg == PH_DONE)
                begin
                    state_next = ST_DIGEST;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_DIGEST:
            begin
                if (!out_busy_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath.
    always_comb
    begin
        phase_next    = phase_reg;
        chain_next    = chain_reg;
        rv_next       = rv_reg;
        w_next        = w_reg;
        acc_next      = acc_reg;
        byte_cnt_next = byte_cnt_reg;
        bit_cnt_next  = bit_cnt_reg;
        round_next    = round_reg;
        dig_next      = dig_reg;
        out_idx_next  = out_idx_reg;
        out_busy_next = out_busy_reg;

        if (wr_en)
        begin
            acc_next      = {acc_reg[15:0], wr_byte};
            byte_cnt_next = byte_cnt_reg + 6'd1;
            if (byte_cnt_reg[1:0] == 2'b11)
            begin
                w_next = {{acc_reg, wr_byte}, w_reg[15:1]};
            end
        end

        if (block_full)
        begin
            rv_next    = chain_reg;
            round_next = 7'd0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_take && byte_present)
                begin
                    bit_cnt_next = bit_cnt_reg + 64'd8;
                end
                if (msg_take && end_of_message)
                begin
                    phase_next = PH_MARK;
                end
            end
            ST_PAD:
            begin
                if (phase_reg == PH_LEN)
                begin
                    if (byte_cnt_reg == 6'd63)
                    begin
                        phase_next = PH_DONE;
                    end
                end
                else if (byte_cnt_reg == 6'd55)
                begin
                    phase_next = PH_LEN;
                end
                else
                begin
                    phase_next = PH_ZERO;
                end
            end
            ST_ROUND:
            begin
                rv_next    = {rv_reg[3], rv_reg[2], {rv_reg[1][1:0], rv_reg[1][31:2]},
                              rv_reg[0], round_sum};
                // w[t+16] = rotl1(w[t+13] ^ w[t+8] ^ w[t+2] ^ w[t])
                w_next     = {{w_reg[13][30:0] ^ w_reg[8][30:0] ^ w_reg[2][30:0]
                               ^ w_reg[0][30:0],
                               w_reg[13][31] ^ w_reg[8][31] ^ w_reg[2][31] ^ w_reg[0][31]},
                              w_reg[15:1]};
                round_next = round_reg + 7'd1;
            end
            ST_ADD:
            begin
                for (int i = 0; i < 5; i++)
                begin
                    chain_next[i] = chain_reg[i] + rv_reg[i];
                end
            end
            ST_DIGEST:
            begin
                if (!out_busy_reg)
                begin
                    dig_next      = chain_reg;
                    out_busy_next = 1'b1;
                    out_idx_next  = 3'd0;
                    chain_next    = H_INIT;
                    bit_cnt_next  = 64'd0;
                    phase_next    = PH_NONE;
                end
            end
            default: ;
        endcase

        if (out_take)
        begin
            dig_next = {32'h0, dig_reg[4:1]};
            if (out_idx_reg == 3'd4)
            begin
                out_busy_next = 1'b0;
                out_idx_next  = 3'd0;
            end
            else
            begin
                out_idx_next = out_idx_reg + 3'd1;
            end
        end
    end

    // Outputs.
    always_comb
    begin
        msg_stall    = (state_reg != ST_IDLE);
        digest_valid = out_busy_reg;
        digest_word  = dig_reg[0];
        word_number  = out_idx_reg;
        last_word    = (out_idx_reg == 3'd4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_NONE;
            chain_reg    <= H_INIT;
            byte_cnt_reg <= 6'd0;
            bit_cnt_reg  <= 64'd0;
            round_reg    <= 7'd0;
            out_idx_reg  <= 3'd0;
            out_busy_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            chain_reg    <= chain_next;
            byte_cnt_reg <= byte_cnt_next;
            bit_cnt_reg  <= bit_cnt_next;
            round_reg    <= round_next;
            out_idx_reg  <= out_idx_next;
            out_busy_reg <= out_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rv_reg  <= rv_next;
        w_reg   <= w_next;
        acc_reg <= acc_next;
        dig_reg <= dig_next;
    end

`include "sha1_hash_engine_assert.svh"

    `SHA1_ASSERT_NOW(a_round_range, state_reg == ST_ROUND, round_reg < 7'(ROUNDS), "round index out of range")
    `SHA1_ASSERT_NOW(a_round_aligned, state_reg == ST_ROUND, byte_cnt_reg == 6'd0, "rounds running on a partial block")
    `SHA1_ASSERT_NEXT(a_add_to_digest, state_reg == ST_ADD && phase_reg == PH_DONE, state_reg == ST_DIGEST, "final block did not lead to digest")
    `SHA1_ASSERT_NEXT(a_word_order, out_take && !last_word, digest_valid && word_number == $past(word_number) + 3'd1, "digest words out of order")

endmodule
